FILE: hdl/protobuf_two_field_extractor_top_defines.svh
// assertion macros shared by the extractor modules
`ifndef PROTOBUF_TWO_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define PROTOBUF_TWO_FIELD_EXTRACTOR_TOP_DEFINES_SVH

// property that must hold in the same cycle
`define PBX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define PBX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pbx_pkg.sv
package pbx_pkg;

	localparam int unsigned MAX_VARINT_BYTES = 10;

	typedef enum logic [2:0] {
		PH_KEY        = 3'd0,
		PH_LAYOUT     = 3'd1,
		PH_LEN_BUTTON = 3'd2,
		PH_BUTTON     = 3'd3,
		PH_SKIP_VAR   = 3'd4,
		PH_LEN_SKIP   = 3'd5,
		PH_SKIP_BYTES = 3'd6
	} phase_t;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_VAR_TRUNC   = 3'd1;
	localparam logic [2:0] ST_VAR_LONG    = 3'd2;
	localparam logic [2:0] ST_FIELD_TRUNC = 3'd3;
	localparam logic [2:0] ST_BAD_WIRE    = 3'd4;
	localparam logic [2:0] ST_MISSING     = 3'd5;

	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       empty_payload;
	} item_t;

	typedef struct packed {
		logic        button_start;
		logic        button_valid;
		logic [7:0]  button_byte;
		logic        layout_valid;
		logic [31:0] layout_value;
		logic        finished;
		logic [2:0]  status;
	} result_t;

endpackage

FILE: hdl/pbx_stream_ifs.sv
interface pbx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       empty_payload;

	modport source (output valid, data_byte, last_byte, empty_payload, input ready);
	modport sink (input valid, data_byte, last_byte, empty_payload, output ready);
endinterface

interface pbx_out_if;
	logic        valid;
	logic        ready;
	logic        button_start;
	logic        button_valid;
	logic [7:0]  button_byte;
	logic        layout_valid;
	logic [31:0] layout_value;
	logic        finished;
	logic [2:0]  status;

	modport source (output valid, button_start, button_valid, button_byte, layout_valid,
		layout_value, finished, status, input ready);
	modport sink (input valid, button_start, button_valid, button_byte, layout_valid,
		layout_value, finished, status, output ready);
endinterface

FILE: hdl/pbx_in_reg.sv
module pbx_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pbx_pkg::item_t in_item,
	output logic           valid_s1,
	input  logic           take,
	output pbx_pkg::item_t item_s1
);
	import pbx_pkg::*;

	// stage empties or drains in the same cycle it refills
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end
endmodule

FILE: hdl/pbx_core.sv
`include "protobuf_two_field_extractor_top_defines.svh"

module pbx_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  pbx_pkg::item_t   item,
	output pbx_pkg::result_t res
);
	import pbx_pkg::*;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] acc;
		logic [3:0]  cnt;
		logic [63:0] rem;
		logic        have_layout;
		logic        have_button;
		logic        draining;
	} dec_state_t;

	localparam dec_state_t DEC_RESET = '{PH_KEY, 64'd0, 4'd0, 64'd0, 1'b0, 1'b0, 1'b0};
	localparam logic [3:0] MAX_CNT = 4'(MAX_VARINT_BYTES);

	dec_state_t st_q;
	dec_state_t nxt;

	logic [6:0]  shamt;
	logic        cnt_room;
	logic [63:0] var_val;
	logic [3:0]  cnt_inc;
	logic        var_done;
	logic        var_long;
	logic [63:0] rem_dec;

	// status when the payload ends in the given state
	function automatic logic [2:0] end_status(input dec_state_t s);
		if (s.phase == PH_KEY && s.cnt == 4'd0) begin
			return (s.have_layout && s.have_button) ? ST_OK : ST_MISSING;
		end else if (s.phase == PH_BUTTON || s.phase == PH_SKIP_BYTES) begin
			return ST_FIELD_TRUNC;
		end
		return ST_VAR_TRUNC;
	endfunction

	// start of a byte run; a zero length goes straight back to the key
	function automatic dec_state_t start_bytes(input dec_state_t s, input logic [63:0] n,
		input phase_t next_ph);
		dec_state_t r;
		r = s;
		r.rem = n;
		r.phase = (n == 64'd0) ? PH_KEY : next_ph;
		r.acc = 64'd0;
		r.cnt = 4'd0;
		return r;
	endfunction

	function automatic dec_state_t begin_varint(input dec_state_t s, input phase_t next_ph);
		dec_state_t r;
		r = s;
		r.phase = next_ph;
		r.acc = 64'd0;
		r.cnt = 4'd0;
		return r;
	endfunction

	// varint byte merge
	assign shamt    = {3'd0, st_q.cnt} * 7'd7;
	assign cnt_room = st_q.cnt < MAX_CNT;
	assign var_val  = st_q.acc | (cnt_room ? (64'(item.data_byte[6:0]) << shamt) : 64'd0);
	assign cnt_inc  = cnt_room ? st_q.cnt + 4'd1 : st_q.cnt;
	assign var_done = !item.data_byte[7];
	assign var_long = !var_done && (cnt_inc >= MAX_CNT);
	assign rem_dec  = st_q.rem - 64'd1;

	always_comb begin
		logic [2:0] err;
		err = ST_OK;
		nxt = st_q;
		res = '0;
		if (item.empty_payload) begin
			if (!st_q.draining) begin
				res.finished = 1'b1;
				res.status   = end_status(st_q);
			end
			nxt = DEC_RESET;
		end else if (st_q.draining) begin
			if (item.last_byte) begin
				nxt = DEC_RESET;
			end
		end else begin
			case (st_q.phase)
				PH_BUTTON, PH_SKIP_BYTES: begin
					if (st_q.phase == PH_BUTTON) begin
						res.button_valid = 1'b1;
						res.button_byte  = item.data_byte;
					end
					nxt.rem = rem_dec;
					if (rem_dec == 64'd0) begin
						nxt = begin_varint(nxt, PH_KEY);
					end
				end
				default: begin
					if (var_long) begin
						err = ST_VAR_LONG;
					end else if (!var_done) begin
						nxt.acc = var_val;
						nxt.cnt = cnt_inc;
					end else begin
						case (st_q.phase)
							PH_KEY: begin
								if (var_val[34:3] == 32'd1 && var_val[2:0] == WT_VARINT) begin
									nxt = begin_varint(st_q, PH_LAYOUT);
								end else if (var_val[34:3] == 32'd2 && var_val[2:0] == WT_LEN) begin
									nxt = begin_varint(st_q, PH_LEN_BUTTON);
								end else if (var_val[2:0] == WT_VARINT) begin
									nxt = begin_varint(st_q, PH_SKIP_VAR);
								end else if (var_val[2:0] == WT_LEN) begin
									nxt = begin_varint(st_q, PH_LEN_SKIP);
								end else if (var_val[2:0] == WT_FIXED64) begin
									nxt = start_bytes(st_q, 64'd8, PH_SKIP_BYTES);
								end else if (var_val[2:0] == WT_FIXED32) begin
									nxt = start_bytes(st_q, 64'd4, PH_SKIP_BYTES);
								end else begin
									err = ST_BAD_WIRE;
								end
							end
							PH_LAYOUT: begin
								res.layout_valid = 1'b1;
								res.layout_value = var_val[31:0];
								nxt = begin_varint(st_q, PH_KEY);
								nxt.have_layout = 1'b1;
							end
							PH_LEN_BUTTON: begin
								res.button_start = 1'b1;
								nxt = start_bytes(st_q, var_val, PH_BUTTON);
								nxt.have_button = 1'b1;
							end
							PH_LEN_SKIP: begin
								nxt = start_bytes(st_q, var_val, PH_SKIP_BYTES);
							end
							default: begin
								nxt = begin_varint(st_q, PH_KEY);
							end
						endcase
					end
				end
			endcase
			if (err != ST_OK) begin
				res.finished = 1'b1;
				res.status   = err;
				nxt = st_q;
				if (item.last_byte) begin
					nxt = DEC_RESET;
				end else begin
					nxt.draining = 1'b1;
				end
			end else if (item.last_byte) begin
				res.finished = 1'b1;
				res.status   = end_status(nxt);
				nxt = DEC_RESET;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DEC_RESET;
		end else if (take) begin
			st_q <= nxt;
		end
	end

	`PBX_ASSERT(a_cnt_bound, st_q.cnt < MAX_CNT, "varint byte count reached its limit")
	`PBX_ASSERT(a_run_nonzero,
		(st_q.phase == PH_BUTTON || st_q.phase == PH_SKIP_BYTES) |-> st_q.rem != 64'd0,
		"byte run phase with nothing left")
	`PBX_ASSERT(a_drain_silent, (take && st_q.draining && !item.empty_payload) |-> res == '0,
		"result while dropping bytes after an error")
	`PBX_ASSERT_NEXT(a_err_drain,
		take && res.finished && res.status != ST_OK && !item.last_byte && !item.empty_payload
			&& !st_q.draining && (res.status == ST_VAR_LONG || res.status == ST_BAD_WIRE),
		st_q.draining, "error mid payload did not start the drain")
endmodule

FILE: hdl/pbx_out_skid.sv
`include "protobuf_two_field_extractor_top_defines.svh"

module pbx_out_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  pbx_pkg::result_t push_data,
	output logic             out_valid,
	input  logic             out_ready,
	output pbx_pkg::result_t out_data
);
	import pbx_pkg::*;

	logic    skid_valid_q;
	result_t skid_q;
	logic    pop;

	assign push_ready = !skid_valid_q;
	assign pop        = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid <= push;
			end
		end else if (push) begin
			if (out_valid) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_data <= skid_q;
		end else if (push && (pop || !out_valid)) begin
			out_data <= push_data;
		end
		if (push && out_valid && !pop) begin
			skid_q <= push_data;
		end
	end

	`PBX_ASSERT(a_skid_order, skid_valid_q |-> out_valid, "skid entry held with empty output")
endmodule

FILE: hdl/protobuf_two_field_extractor_top.sv
// protobuf payload extractor: pulls a layout handle (field 1) and a button id
// (field 2) out of a wire-format byte stream
// payload channel: one byte per item, last_byte marks the end of a payload and
// empty_payload stands for a payload of no bytes at all
// result channel: exactly one result item for every payload item, in order
// path: each payload item is registered in the input stage, and its result then
// in the result register, from which the receiver takes it
// throughput: one item per cycle while the receiver keeps taking results, set
// by the single decoder step between the input stage and the result register
// reset: clears the decoder state to a fresh payload boundary and empties
// both the input stage and the result register
// receiver stall: the result register holds, a skid entry catches one more
// result and the input stage then holds its item, so payload ready falls
// within two items of the stall and nothing is lost
module protobuf_two_field_extractor_top (
	input logic clk,
	input logic arst_n,
	pbx_in_if.sink    payload,
	pbx_out_if.source result
);
	import pbx_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    take;
	logic    skid_ready;
	result_t step_res;
	result_t out_res;

	assign in_item.data_byte     = payload.data_byte;
	assign in_item.last_byte     = payload.last_byte;
	assign in_item.empty_payload = payload.empty_payload;

	// decoder steps only when the result side can hold the item
	assign take = valid_s1 && skid_ready;

	// input stage
	pbx_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (payload.valid),
		.in_ready (payload.ready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.take     (take),
		.item_s1  (item_s1)
	);

	// wire-format decoder with its running state
	pbx_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.res    (step_res)
	);

	// result register with skid entry
	pbx_out_skid u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take),
		.push_ready (skid_ready),
		.push_data  (step_res),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_data   (out_res)
	);

	assign result.button_start = out_res.button_start;
	assign result.button_valid = out_res.button_valid;
	assign result.button_byte  = out_res.button_byte;
	assign result.layout_valid = out_res.layout_valid;
	assign result.layout_value = out_res.layout_value;
	assign result.finished     = out_res.finished;
	assign result.status       = out_res.status;
endmodule
